[design/ray_sphere_closest_hit_core_macros.svh]
// Assertion macros for the ray/sphere closest-hit core.
// No dependencies; included by the files that carry assertions.
`ifndef RAY_SPHERE_CLOSEST_HIT_CORE_MACROS_SVH
`define RAY_SPHERE_CLOSEST_HIT_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RSCH_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define RSCH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rsch_pkg.sv]
// Shared types, constants and helpers for the ray/sphere closest-hit core.
// No dependencies.
`timescale 1ns / 1ps

package rsch_pkg;

    localparam int DEF_NUM_SPHERES = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int SPH_W           = 64;
    localparam int CRD_W           = 16;

    // shared multiplier
    localparam int MUL_W  = 34;
    localparam int PROD_W = 68;

    // shared divide / square-root unit
    localparam int DSU_NUM_W  = 64;
    localparam int DSU_DEN_W  = 32;
    localparam int DSU_Q_W    = 48;
    localparam int DSU_REM_W  = 36;
    localparam int DSU_CNT_W  = 6;
    localparam int SQRT_ITERS = 32;
    localparam int TDIV_ITERS = 42;
    localparam int NDIV_ITERS = 48;

    localparam int DIST_W    = 42;
    localparam int PW_W      = 34;
    localparam int T_MIN_Q88 = 2;

    localparam logic signed [PROD_W-1:0] PW_CLAMP_HI = 68'sh0_0000_0001_0000_0000;
    localparam logic signed [PROD_W-1:0] PW_CLAMP_LO = -PW_CLAMP_HI;

    typedef struct packed {
        logic                   start;
        logic                   sqrt_mode;
        logic [DSU_NUM_W-1:0]   num;
        logic [DSU_DEN_W-1:0]   den;
        logic [DSU_CNT_W-1:0]   iters;
    } dsu_req_t;

    typedef struct packed {
        logic                   done;
        logic [DSU_Q_W-1:0]     q;
    } dsu_rsp_t;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0_0000_0000_0001,
        S_RAYA  = 13'b0_0000_0000_0010,
        S_SPH   = 13'b0_0000_0000_0100,
        S_PROD  = 13'b0_0000_0000_1000,
        S_CHK   = 13'b0_0000_0001_0000,
        S_SQRT  = 13'b0_0000_0010_0000,
        S_ROOT  = 13'b0_0000_0100_0000,
        S_DIV   = 13'b0_0000_1000_0000,
        S_FIN   = 13'b0_0001_0000_0000,
        S_FMUL  = 13'b0_0010_0000_0000,
        S_FGO   = 13'b0_0100_0000_0000,
        S_FWAIT = 13'b0_1000_0000_0000,
        S_OUT   = 13'b1_0000_0000_0000
    } state_t;

    function automatic logic signed [CRD_W-1:0] sat16(input logic signed [49:0] v);
        logic signed [CRD_W-1:0] r;
        if (v > 50'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -50'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[CRD_W-1:0];
        end
        return r;
    endfunction

endpackage

[design/rsch_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on rsch_pkg.
`timescale 1ns / 1ps

module rsch_mul (
    input  logic                               aclk,
    input  logic signed [rsch_pkg::MUL_W-1:0]  a,
    input  logic signed [rsch_pkg::MUL_W-1:0]  b,
    output logic signed [rsch_pkg::PROD_W-1:0] p
);
    import rsch_pkg::*;

    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W-1:0] p_next;

    assign p_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

[design/rsch_divsqrt.sv]
// Shared iterative unit: restoring unsigned divide (one quotient bit per cycle)
// and restoring integer square root (one root bit per cycle). Depends on rsch_pkg.
`timescale 1ns / 1ps

module rsch_divsqrt (
    input  logic               aclk,
    input  logic               aresetn,
    input  rsch_pkg::dsu_req_t req,
    output rsch_pkg::dsu_rsp_t rsp
);
    import rsch_pkg::*;

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [DSU_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  mode_reg, mode_next;
    logic [DSU_DEN_W-1:0]  den_reg, den_next;
    logic [DSU_NUM_W-1:0]  sh_reg, sh_next;
    logic [DSU_REM_W-1:0]  rem_reg, rem_next;
    logic [DSU_Q_W-1:0]    q_reg, q_next;

    logic [DSU_REM_W-1:0]  cand;
    logic [DSU_REM_W-1:0]  sub;
    logic [DSU_REM_W:0]    diff;
    logic                  ge;

    // one subtractor serves both modes
    always_comb begin
        if (mode_reg) begin
            cand = {rem_reg[DSU_REM_W-3:0], sh_reg[DSU_NUM_W-1 -: 2]};
            sub  = {q_reg[DSU_REM_W-3:0], 2'b01};
        end else begin
            cand = {rem_reg[DSU_REM_W-2:0], sh_reg[DSU_NUM_W-1]};
            sub  = DSU_REM_W'(den_reg);
        end
        diff = {1'b0, cand} - {1'b0, sub};
        ge   = ~diff[DSU_REM_W];
    end

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mode_next = mode_reg;
        den_next  = den_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (req.start) begin
            run_next  = 1'b1;
            cnt_next  = req.iters;
            mode_next = req.sqrt_mode;
            den_next  = req.den;
            sh_next   = req.num;
            rem_next  = '0;
            q_next    = '0;
        end else if (run_reg) begin
            sh_next  = mode_reg ? (sh_reg << 2) : (sh_reg << 1);
            rem_next = ge ? diff[DSU_REM_W-1:0] : cand;
            q_next   = {q_reg[DSU_Q_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DSU_CNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        den_reg  <= den_next;
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

endmodule

[design/ray_sphere_closest_hit_core.sv]
// Ray vs. sphere-set closest-hit core. One ray at a time; s_ready only in idle.
// Per sphere: skip on zero radius or zero A, stop on no real root, else a square root
//   and one or two divides; on a hit, the hit point multiplies and three normal divides follow.
// A new ray is taken only after the result transfers with m_ready high; the iterative
//   divide/sqrt unit sets the pace.
// Reset: aresetn synchronous active low; sphere registers clear to zero.
`timescale 1ns / 1ps
`include "ray_sphere_closest_hit_core_macros.svh"

module ray_sphere_closest_hit_core #(
    parameter int NUM_SPHERES = rsch_pkg::DEF_NUM_SPHERES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [rsch_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rsch_pkg::SPH_W-1:0]          cfg_data,
    // ray in
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [rsch_pkg::CRD_W-1:0]   s_origin_x,
    input  logic signed [rsch_pkg::CRD_W-1:0]   s_origin_y,
    input  logic signed [rsch_pkg::CRD_W-1:0]   s_origin_z,
    input  logic signed [rsch_pkg::CRD_W-1:0]   s_direction_x,
    input  logic signed [rsch_pkg::CRD_W-1:0]   s_direction_y,
    input  logic signed [rsch_pkg::CRD_W-1:0]   s_direction_z,
    // hit out
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic [rsch_pkg::CRD_W-1:0]          m_hit_distance,
    output logic signed [rsch_pkg::CRD_W-1:0]   m_point_x,
    output logic signed [rsch_pkg::CRD_W-1:0]   m_point_y,
    output logic signed [rsch_pkg::CRD_W-1:0]   m_point_z,
    output logic signed [rsch_pkg::CRD_W-1:0]   m_normal_x,
    output logic signed [rsch_pkg::CRD_W-1:0]   m_normal_y,
    output logic signed [rsch_pkg::CRD_W-1:0]   m_normal_z
);
    import rsch_pkg::*;

    localparam int KW = (NUM_SPHERES > 1) ? $clog2(NUM_SPHERES) : 1;

    // sphere registers: cx[15:0] cy[31:16] cz[47:32] r[63:48]
    logic [SPH_W-1:0] sph_reg [NUM_SPHERES];
    logic             cfg_hit;

    assign cfg_hit = cfg_wr_en &&
                     ({1'b0, cfg_index} < (CFG_IDX_W + 1)'(NUM_SPHERES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SPHERES; i++) begin
                sph_reg[i] <= '0;
            end
        end else if (cfg_hit) begin
            sph_reg[cfg_index[KW-1:0]] <= cfg_data;
        end
    end

    // control
    state_t          state_reg, state_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [KW-1:0]   bk_reg, bk_next;
    logic            root_reg, root_next;
    logic            hit_reg, hit_next;

    // datapath
    logic signed [CRD_W-1:0]  o_reg [3], o_next [3];
    logic signed [CRD_W-1:0]  d_reg [3], d_next [3];
    logic signed [16:0]       oc_reg [3], oc_next [3];
    logic [31:0]              a_reg, a_next;
    logic signed [34:0]       b_reg, b_next;
    logic signed [35:0]       c_reg, c_next;
    logic signed [65:0]       disc_reg, disc_next;
    logic [31:0]              s_reg, s_next;
    logic                     nneg_reg, nneg_next;
    logic [DIST_W-1:0]        best_reg, best_next;
    logic signed [PROD_W-1:0] tmp_reg, tmp_next;
    logic signed [PW_W-1:0]   pw_reg [3], pw_next [3];
    logic signed [CRD_W-1:0]  pt_reg [3], pt_next [3];
    logic signed [CRD_W-1:0]  nm_reg [3], nm_next [3];

    // shared units
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    dsu_req_t                 dsu_req;
    dsu_rsp_t                 dsu_rsp;

    rsch_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    rsch_divsqrt u_dsu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dsu_req),
        .rsp     (dsu_rsp)
    );

    // current sphere and best sphere fields
    logic [SPH_W-1:0]        cur_sph, best_sph;
    logic signed [CRD_W-1:0] cur_cen [3];
    logic signed [CRD_W-1:0] cur_r, best_r;
    logic [CRD_W-1:0]        best_rmag;

    assign cur_sph    = sph_reg[k_reg];
    assign best_sph   = sph_reg[bk_reg];
    assign cur_cen[0] = cur_sph[15:0];
    assign cur_cen[1] = cur_sph[31:16];
    assign cur_cen[2] = cur_sph[47:32];
    assign cur_r      = cur_sph[63:48];
    assign best_r     = best_sph[63:48];
    assign best_rmag  = best_r[CRD_W-1] ? CRD_W'(-best_r) : best_r;

    // quadratic terms floored by two fraction bits
    logic [29:0]        aq;
    logic signed [32:0] bq;
    logic signed [33:0] cq;

    assign aq = a_reg[31:2];
    assign bq = b_reg[34:2];
    assign cq = c_reg[35:2];

    // root numerator n = -B -/+ sqrt(D)
    logic signed [34:0] sx, root_n, root_mag;

    assign sx       = {3'b000, s_reg};
    assign root_n   = -35'(bq) + (root_reg ? sx : -sx);
    assign root_mag = root_n[34] ? -root_n : root_n;

    // hit point accumulate: pw = o + floor(t*d/256), clamped to +-2^32
    logic [3:0]               acc_j;
    logic [1:0]               fm_i;
    logic signed [CRD_W-1:0]  fm_o;
    logic signed [PROD_W-1:0] fm_sum, fm_w;
    logic signed [PW_W-1:0]   fm_pw;

    assign acc_j  = cnt_reg - 4'd1;
    assign fm_i   = acc_j[2:1];
    assign fm_sum = tmp_reg + prod;

    always_comb begin
        case (fm_i)
            2'd0:    fm_o = o_reg[0];
            2'd1:    fm_o = o_reg[1];
            default: fm_o = o_reg[2];
        endcase
        fm_w = PROD_W'(fm_o) + (fm_sum >>> 8);
        if (fm_w > PW_CLAMP_HI) begin
            fm_pw = PW_W'(PW_CLAMP_HI);
        end else if (fm_w < PW_CLAMP_LO) begin
            fm_pw = PW_W'(PW_CLAMP_LO);
        end else begin
            fm_pw = PW_W'(fm_w);
        end
    end

    // normal numerator v = pw - center of the best sphere
    logic [1:0]              fg_i;
    logic signed [PW_W-1:0]  fg_pw;
    logic signed [CRD_W-1:0] fg_cen;
    logic signed [34:0]      fg_v, fg_vmag;

    assign fg_i = cnt_reg[1:0];

    always_comb begin
        case (fg_i)
            2'd0: begin
                fg_pw  = pw_reg[0];
                fg_cen = best_sph[15:0];
            end
            2'd1: begin
                fg_pw  = pw_reg[1];
                fg_cen = best_sph[31:16];
            end
            default: begin
                fg_pw  = pw_reg[2];
                fg_cen = best_sph[47:32];
            end
        endcase
        fg_v    = 35'(fg_pw) - 35'(fg_cen);
        fg_vmag = fg_v[34] ? -fg_v : fg_v;
    end

    // results from the divide/sqrt unit
    logic [DIST_W-1:0]  tq;
    logic               t_accept;
    logic signed [49:0] nq, nv;

    assign tq       = dsu_rsp.q[DIST_W-1:0];
    assign t_accept = !nneg_reg && (tq > DIST_W'(T_MIN_Q88)) && (!hit_reg || (tq < best_reg));
    assign nq       = {2'b00, dsu_rsp.q};
    assign nv       = nneg_reg ? -nq : nq;

    // multiplier operand select by sequencer step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_RAYA: begin
                case (cnt_reg)
                    4'd0: begin mul_a = MUL_W'(d_reg[0]); mul_b = MUL_W'(d_reg[0]); end
                    4'd1: begin mul_a = MUL_W'(d_reg[1]); mul_b = MUL_W'(d_reg[1]); end
                    4'd2: begin mul_a = MUL_W'(d_reg[2]); mul_b = MUL_W'(d_reg[2]); end
                    default: ;
                endcase
            end
            S_PROD: begin
                case (cnt_reg)
                    4'd0: begin mul_a = MUL_W'(oc_reg[0]); mul_b = MUL_W'(d_reg[0]); end
                    4'd1: begin mul_a = MUL_W'(oc_reg[1]); mul_b = MUL_W'(d_reg[1]); end
                    4'd2: begin mul_a = MUL_W'(oc_reg[2]); mul_b = MUL_W'(d_reg[2]); end
                    4'd3: begin mul_a = MUL_W'(oc_reg[0]); mul_b = MUL_W'(oc_reg[0]); end
                    4'd4: begin mul_a = MUL_W'(oc_reg[1]); mul_b = MUL_W'(oc_reg[1]); end
                    4'd5: begin mul_a = MUL_W'(oc_reg[2]); mul_b = MUL_W'(oc_reg[2]); end
                    4'd6: begin mul_a = MUL_W'(cur_r);     mul_b = MUL_W'(cur_r); end
                    4'd7: begin mul_a = MUL_W'(bq);        mul_b = MUL_W'(bq); end
                    4'd8: begin mul_a = {4'b0000, aq};     mul_b = cq; end
                    default: ;
                endcase
            end
            S_FMUL: begin
                // t split into high and low 21-bit halves
                case (cnt_reg)
                    4'd0: begin mul_a = {13'd0, best_reg[41:21]}; mul_b = MUL_W'(d_reg[0]); end
                    4'd1: begin mul_a = {13'd0, best_reg[20:0]};  mul_b = MUL_W'(d_reg[0]); end
                    4'd2: begin mul_a = {13'd0, best_reg[41:21]}; mul_b = MUL_W'(d_reg[1]); end
                    4'd3: begin mul_a = {13'd0, best_reg[20:0]};  mul_b = MUL_W'(d_reg[1]); end
                    4'd4: begin mul_a = {13'd0, best_reg[41:21]}; mul_b = MUL_W'(d_reg[2]); end
                    4'd5: begin mul_a = {13'd0, best_reg[20:0]};  mul_b = MUL_W'(d_reg[2]); end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        bk_next    = bk_reg;
        root_next  = root_reg;
        hit_next   = hit_reg;
        o_next     = o_reg;
        d_next     = d_reg;
        oc_next    = oc_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        disc_next  = disc_reg;
        s_next     = s_reg;
        nneg_next  = nneg_reg;
        best_next  = best_reg;
        tmp_next   = tmp_reg;
        pw_next    = pw_reg;
        pt_next    = pt_reg;
        nm_next    = nm_reg;
        dsu_req    = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    o_next[0]  = s_origin_x;
                    o_next[1]  = s_origin_y;
                    o_next[2]  = s_origin_z;
                    d_next[0]  = s_direction_x;
                    d_next[1]  = s_direction_y;
                    d_next[2]  = s_direction_z;
                    a_next     = '0;
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    k_next     = KW'(NUM_SPHERES - 1);
                    state_next = S_RAYA;
                end
            end
            S_RAYA: begin
                // a = d.d, shared by every sphere
                if (cnt_reg != 4'd0) begin
                    a_next = a_reg + 32'(prod);
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd3) begin
                    state_next = S_SPH;
                end
            end
            S_SPH: begin
                for (int i = 0; i < 3; i++) begin
                    oc_next[i] = 17'(o_reg[i]) - 17'(cur_cen[i]);
                end
                b_next   = '0;
                c_next   = '0;
                cnt_next = '0;
                if ((cur_r == '0) || (aq == '0)) begin
                    if (k_reg == '0) begin
                        state_next = S_FIN;
                    end else begin
                        k_next     = k_reg - 1'b1;
                        state_next = S_SPH;
                    end
                end else begin
                    state_next = S_PROD;
                end
            end
            S_PROD: begin
                // product issued at step j lands at step j+1
                case (acc_j) inside
                    [4'd0:4'd2]: b_next = b_reg + 35'(prod);
                    [4'd3:4'd5]: c_next = c_reg + 36'(prod);
                    4'd6:        c_next = c_reg - 36'(prod);
                    4'd7:        disc_next = 66'(prod);
                    4'd8:        disc_next = disc_reg - 66'(prod);
                    default: ;
                endcase
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd9) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (disc_reg[65] || (disc_reg == '0)) begin
                    if (k_reg == '0) begin
                        state_next = S_FIN;
                    end else begin
                        k_next     = k_reg - 1'b1;
                        state_next = S_SPH;
                    end
                end else begin
                    dsu_req.start     = 1'b1;
                    dsu_req.sqrt_mode = 1'b1;
                    dsu_req.num       = disc_reg[DSU_NUM_W-1:0];
                    dsu_req.iters     = DSU_CNT_W'(SQRT_ITERS);
                    state_next        = S_SQRT;
                end
            end
            S_SQRT: begin
                if (dsu_rsp.done) begin
                    s_next     = dsu_rsp.q[31:0];
                    root_next  = 1'b0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT: begin
                // t = (n * 256) / A, magnitude divide then sign
                dsu_req.start = 1'b1;
                dsu_req.num   = {root_mag[33:0], 30'd0};
                dsu_req.den   = {2'b00, aq};
                dsu_req.iters = DSU_CNT_W'(TDIV_ITERS);
                nneg_next     = root_n[34];
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (dsu_rsp.done) begin
                    if (t_accept || root_reg) begin
                        if (t_accept) begin
                            best_next = tq;
                            hit_next  = 1'b1;
                            bk_next   = k_reg;
                        end
                        if (k_reg == '0) begin
                            state_next = S_FIN;
                        end else begin
                            k_next     = k_reg - 1'b1;
                            state_next = S_SPH;
                        end
                    end else begin
                        root_next  = 1'b1;
                        state_next = S_ROOT;
                    end
                end
            end
            S_FIN: begin
                cnt_next = '0;
                if (hit_reg) begin
                    state_next = S_FMUL;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        pt_next[i] = '0;
                        nm_next[i] = '0;
                    end
                    state_next = S_OUT;
                end
            end
            S_FMUL: begin
                if (cnt_reg != 4'd0) begin
                    if (!acc_j[0]) begin
                        tmp_next = prod <<< 21;
                    end else begin
                        pw_next[fm_i] = fm_pw;
                    end
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd6) begin
                    cnt_next   = '0;
                    state_next = S_FGO;
                end
            end
            S_FGO: begin
                // normal = (pw - center) * 16384 / r, truncated toward zero
                dsu_req.start = 1'b1;
                dsu_req.num   = {fg_vmag[33:0], 30'd0};
                dsu_req.den   = {16'd0, best_rmag};
                dsu_req.iters = DSU_CNT_W'(NDIV_ITERS);
                nneg_next     = fg_v[34] ^ best_r[CRD_W-1];
                state_next    = S_FWAIT;
            end
            S_FWAIT: begin
                if (dsu_rsp.done) begin
                    nm_next[fg_i] = sat16(nv);
                    if (cnt_reg == 4'd2) begin
                        for (int i = 0; i < 3; i++) begin
                            pt_next[i] = sat16(50'(pw_reg[i]));
                        end
                        state_next = S_OUT;
                    end else begin
                        cnt_next   = cnt_reg + 4'd1;
                        state_next = S_FGO;
                    end
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
            bk_reg    <= '0;
            root_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            bk_reg    <= bk_next;
            root_reg  <= root_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        o_reg    <= o_next;
        d_reg    <= d_next;
        oc_reg   <= oc_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        disc_reg <= disc_next;
        s_reg    <= s_next;
        nneg_reg <= nneg_next;
        best_reg <= best_next;
        tmp_reg  <= tmp_next;
        pw_reg   <= pw_next;
        pt_reg   <= pt_next;
        nm_reg   <= nm_next;
    end

    // result port; held steady through the transfer
    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = (state_reg == S_OUT);
    assign m_hit          = hit_reg;
    assign m_hit_distance = !hit_reg ? '0 :
                            (best_reg > DIST_W'(16'hFFFF)) ? 16'hFFFF : best_reg[CRD_W-1:0];
    assign m_point_x      = pt_reg[0];
    assign m_point_y      = pt_reg[1];
    assign m_point_z      = pt_reg[2];
    assign m_normal_x     = nm_reg[0];
    assign m_normal_y     = nm_reg[1];
    assign m_normal_z     = nm_reg[2];

    `RSCH_ASSERT_IMPL(a_one_ray, aclk, aresetn, m_valid, !s_ready,
        "ray taken while result pending")
    `RSCH_ASSERT_IMPL(a_miss_zero, aclk, aresetn, m_valid && !m_hit,
        (m_hit_distance == '0) && (m_point_x == '0) && (m_normal_x == '0),
        "miss result not zero")
    `RSCH_ASSERT_IMPL(a_hit_tmin, aclk, aresetn, m_valid && m_hit,
        m_hit_distance > CRD_W'(T_MIN_Q88), "hit distance not above minimum")
    `RSCH_ASSERT_IMPL(a_dsu_owner, aclk, aresetn, dsu_rsp.done,
        (state_reg == S_SQRT) || (state_reg == S_DIV) || (state_reg == S_FWAIT),
        "divide/sqrt finished with no waiter")
    `RSCH_ASSERT_NEXT(a_ray_start, aclk, aresetn, s_valid && s_ready,
        state_reg == S_RAYA, "accepted ray did not start")

endmodule
